/* sv/rdpd_pkg.sv */
// ----------------------------------------------------------------------------
// rdpd_pkg
// shared types and constants for the rotary dial pulse decoder
// ----------------------------------------------------------------------------
package rdpd_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int NOW_WIDTH  = 32;
   localparam int CFG_WIDTH  = 16;
   localparam int CNT_WIDTH  = 4;
   localparam int IDX_WIDTH  = 3;

   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 8;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [CFG_WIDTH-1:0]  cfg_word_type;
   typedef logic [CNT_WIDTH-1:0]  count_type;

   typedef enum logic [IDX_WIDTH-1:0] {
      REG_MIN_CLOSURE = 3'd0,
      REG_MIN_OPEN    = 3'd1,
      REG_MAX_OPEN    = 3'd2,
      REG_MIN_PERIOD  = 3'd3,
      REG_MAX_PERIOD  = 3'd4,
      REG_MAX_PULSES  = 3'd5,
      REG_INTERDIGIT  = 3'd6,
      REG_SETTLE      = 3'd7
   } reg_index_type;

   typedef enum logic {
      CMD_LOOP_CHANGE = 1'b0,
      CMD_POLL        = 1'b1
   } command_type;

   localparam cfg_word_type RST_MIN_CLOSURE = 16'd25;
   localparam cfg_word_type RST_MIN_OPEN    = 16'd53;
   localparam cfg_word_type RST_MAX_OPEN    = 16'd125;
   localparam cfg_word_type RST_MIN_PERIOD  = 16'd84;
   localparam cfg_word_type RST_MAX_PERIOD  = 16'd125;
   localparam count_type    RST_MAX_PULSES  = 4'd10;
   localparam cfg_word_type RST_INTERDIGIT  = 16'd400;
   localparam cfg_word_type RST_SETTLE      = 16'd500;

   localparam count_type COUNT_SATURATE = 4'd15;
   localparam count_type DIGIT_BASE     = 4'd10;

   typedef struct packed {
      cfg_word_type min_closure;
      cfg_word_type min_open;
      cfg_word_type max_open;
      cfg_word_type min_period;
      cfg_word_type max_period;
      count_type    max_pulses;
      cfg_word_type interdigit;
      cfg_word_type settle;
   } cfg_type;

   typedef struct packed {
      command_type command;
      time_type    now;
      logic        loop_closed;
   } item_type;

   typedef struct packed {
      logic      digit_valid;
      count_type digit;
   } result_type;

endpackage

/* sv/rdpd_csr.sv */
// ----------------------------------------------------------------------------
// rdpd_csr
// configuration register file with write-only access
// ----------------------------------------------------------------------------
module rdpd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [rdpd_pkg::IDX_WIDTH-1:0] csr_index,
   input  logic [rdpd_pkg::CFG_WIDTH-1:0] csr_wdata,
   output rdpd_pkg::cfg_type            cfg
);
   import rdpd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_MIN_CLOSURE: cfg_in.min_closure = csr_wdata;
            REG_MIN_OPEN:    cfg_in.min_open    = csr_wdata;
            REG_MAX_OPEN:    cfg_in.max_open    = csr_wdata;
            REG_MIN_PERIOD:  cfg_in.min_period  = csr_wdata;
            REG_MAX_PERIOD:  cfg_in.max_period  = csr_wdata;
            REG_MAX_PULSES:  cfg_in.max_pulses  = csr_wdata[CNT_WIDTH-1:0];
            REG_INTERDIGIT:  cfg_in.interdigit  = csr_wdata;
            REG_SETTLE:      cfg_in.settle      = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_closure <= RST_MIN_CLOSURE;
         cfg_ff.min_open    <= RST_MIN_OPEN;
         cfg_ff.max_open    <= RST_MAX_OPEN;
         cfg_ff.min_period  <= RST_MIN_PERIOD;
         cfg_ff.max_period  <= RST_MAX_PERIOD;
         cfg_ff.max_pulses  <= RST_MAX_PULSES;
         cfg_ff.interdigit  <= RST_INTERDIGIT;
         cfg_ff.settle      <= RST_SETTLE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/rdpd_engine.sv */
// ----------------------------------------------------------------------------
// rdpd_engine
// pulse qualifier, pulse counter and digit poll logic with decoder state
// ----------------------------------------------------------------------------
module rdpd_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  rdpd_pkg::cfg_type    cfg,
   input  logic                 fire,
   input  rdpd_pkg::item_type   item,
   output rdpd_pkg::result_type result
);
   import rdpd_pkg::*;

   logic      awaiting_ff, awaiting_in;
   time_type  last_edge_ff, last_edge_in;
   time_type  last_pulse_ff, last_pulse_in;
   time_type  last_poll_ff, last_poll_in;
   count_type count_ff, count_in;
   logic      taken_ff, taken_in;

   time_type  width;
   time_type  period;
   time_type  poll_gap;
   time_type  settle_gap;
   logic      pulse_ok;

   assign width      = item.now - last_edge_ff;
   assign period     = item.now - last_pulse_ff;
   assign poll_gap   = item.now - last_poll_ff;
   assign settle_gap = item.now - last_pulse_ff;

   assign pulse_ok = item.loop_closed
                  && (width > time_type'(cfg.min_open))
                  && (width < time_type'(cfg.max_open));

   always_comb begin
      awaiting_in   = awaiting_ff;
      last_edge_in  = last_edge_ff;
      last_pulse_in = last_pulse_ff;
      last_poll_in  = last_poll_ff;
      count_in      = count_ff;
      taken_in      = taken_ff;
      result        = '0;

      if (item.command == CMD_LOOP_CHANGE) begin
         last_edge_in = item.now;
         if (item.now >= last_edge_ff) begin
            if (!awaiting_ff) begin
               if (!item.loop_closed && (width > time_type'(cfg.min_closure))) begin
                  awaiting_in = 1'b1;
               end
            end else begin
               awaiting_in = 1'b0;
               if (pulse_ok) begin
                  last_pulse_in = item.now;
                  if (item.now < last_pulse_ff) begin
                     count_in = '0;
                  end else if (period >= time_type'(cfg.min_period)) begin
                     if ((period > time_type'(cfg.max_period))
                         || (count_ff > cfg.max_pulses)
                         || (count_ff == COUNT_SATURATE)) begin
                        count_in = count_type'(1);
                        taken_in = 1'b0;
                     end else begin
                        count_in = count_ff + count_type'(1);
                     end
                  end
               end
            end
         end
      end else begin
         if (item.now < last_poll_ff) begin
            last_poll_in = item.now;
         end else if (poll_gap >= time_type'(cfg.interdigit)) begin
            last_poll_in = item.now;
            if ((item.now >= last_pulse_ff) && (count_ff != '0)
                && (settle_gap >= time_type'(cfg.settle)) && !taken_ff) begin
               taken_in           = 1'b1;
               result.digit_valid = 1'b1;
               result.digit       = (count_ff >= DIGIT_BASE) ? count_ff - DIGIT_BASE
                                                             : count_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff   <= 1'b0;
         last_edge_ff  <= '0;
         last_pulse_ff <= '0;
         last_poll_ff  <= '0;
         count_ff      <= '0;
         taken_ff      <= 1'b0;
      end else if (fire) begin
         awaiting_ff   <= awaiting_in;
         last_edge_ff  <= last_edge_in;
         last_pulse_ff <= last_pulse_in;
         last_poll_ff  <= last_poll_in;
         count_ff      <= count_in;
         taken_ff      <= taken_in;
      end
   end

endmodule

/* sv/rotary_dial_pulse_decoder_core.sv */
// ----------------------------------------------------------------------------
// rotary_dial_pulse_decoder_core
// rotary dial pulse decoder: loop change and digit poll words in, one result
// word out per input word
// ----------------------------------------------------------------------------
// data path: an accepted word is held in the input register, then the engine
//    update writes its result into the result register
// throughput: one word per cycle, limited only by the result handshake
// reset: synchronous; registers return to their defaults, decoder state and
//    both pipeline stages are cleared
module rotary_dial_pulse_decoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms [31:0], loop_closed [32], zero fill
   input  logic [rdpd_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // command [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // digit [3:0], zero fill
   output logic [rdpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // digit_valid [0]
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [rdpd_pkg::IDX_WIDTH-1:0]      csr_index,
   input  logic [rdpd_pkg::CFG_WIDTH-1:0]      csr_wdata
);
   import rdpd_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       out_advance;
   logic       req_fire;

   assign out_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !item_valid_ff || out_advance;
   assign req_fire    = req_tvalid && req_tready;

   rdpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdpd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (item_valid_ff && out_advance),
      .item   (item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.command     <= command_type'(req_tuser);
         item_ff.now         <= time_type'(req_tdata[NOW_WIDTH-1:0]);
         item_ff.loop_closed <= req_tdata[NOW_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_advance && item_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.digit_valid;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - CNT_WIDTH){1'b0}}, rsp_ff.digit};

endmodule

/* sim/tb_rotary_dial_pulse_decoder_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotary_dial_pulse_decoder_core
// self-checking bench for the rotary dial pulse decoder: a short directed
// table, then dial trains with random timing under several register settings,
// each result word checked against a table value or a cycle-free model of the decoder
// ----------------------------------------------------------------------------
module tb_rotary_dial_pulse_decoder_core;

   import rdpd_pkg::*;

   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned PHASE_WORDS = 205;
   localparam int unsigned HOLD_CYCLES = 60;
   localparam result_type  NO_DIGIT    = '0;

   typedef struct packed {
      command_type command;
      time_type    now;
      logic        loop_closed;
      logic        typed;
      result_type  want;
   } row_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_we     = 1'b0;
   logic [IDX_WIDTH-1:0]      csr_index  = '0;
   logic [CFG_WIDTH-1:0]      csr_wdata  = '0;

   cfg_type dial_cfg = '{RST_MIN_CLOSURE, RST_MIN_OPEN, RST_MAX_OPEN, RST_MIN_PERIOD,
                         RST_MAX_PERIOD, RST_MAX_PULSES, RST_INTERDIGIT, RST_SETTLE};
   logic      awaiting_closure = 1'b0;
   time_type  last_edge        = '0;
   time_type  last_pulse       = '0;
   time_type  last_poll        = '0;
   count_type pulse_count      = '0;
   logic      digit_taken      = 1'b0;

   result_type  pending_digits [$];
   item_type    dial_words [$];
   time_type    dial_now     = '0;
   int unsigned sent_count   = 0;
   int unsigned results_seen = 0;
   int unsigned errors       = 0;

   row_type directed_rows [21] = '{
      '{CMD_POLL,        32'd0,          1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd100,        1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd160,        1'b1, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd200,        1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd260,        1'b1, 1'b1, NO_DIGIT},
      '{CMD_POLL,        32'd1000,       1'b1, 1'b0, NO_DIGIT},
      '{CMD_POLL,        32'd1500,       1'b0, 1'b0, NO_DIGIT},
      '{CMD_POLL,        32'd1600,       1'b1, 1'b0, NO_DIGIT},
      // edge and poll going backwards
      '{CMD_LOOP_CHANGE, 32'd50,         1'b0, 1'b1, NO_DIGIT},
      '{CMD_POLL,        32'd10,         1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd4900,       1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd4960,       1'b1, 1'b1, NO_DIGIT},
      // poll earlier than the last pulse
      '{CMD_POLL,        32'd500,        1'b0, 1'b0, NO_DIGIT},
      // pulse going backwards
      '{CMD_LOOP_CHANGE, 32'd100,        1'b1, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd200,        1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd260,        1'b1, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'hFFFF_FFF0,  1'b0, 1'b1, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'hFFFF_FFFF,  1'b1, 1'b1, NO_DIGIT},
      '{CMD_POLL,        32'hFFFF_FFFF,  1'b1, 1'b0, NO_DIGIT},
      '{CMD_LOOP_CHANGE, 32'd0,          1'b0, 1'b1, NO_DIGIT},
      '{CMD_POLL,        32'd0,          1'b0, 1'b1, NO_DIGIT}
   };

   rotary_dial_pulse_decoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic result_type decode_word(item_type w);
      result_type r;
      time_type   span;
      r = NO_DIGIT;
      if (w.command == CMD_LOOP_CHANGE) begin
         if (w.now < last_edge) begin
            last_edge = w.now;
         end else begin
            span      = w.now - last_edge;
            last_edge = w.now;
            if (!awaiting_closure) begin
               if (!w.loop_closed && span > dial_cfg.min_closure) awaiting_closure = 1'b1;
            end else begin
               if (w.loop_closed && span > dial_cfg.min_open && span < dial_cfg.max_open) begin
                  if (w.now < last_pulse) begin
                     last_pulse  = w.now;
                     pulse_count = '0;
                  end else begin
                     span       = w.now - last_pulse;
                     last_pulse = w.now;
                     if (span >= dial_cfg.min_period) begin
                        if (span > dial_cfg.max_period || pulse_count > dial_cfg.max_pulses ||
                            pulse_count == COUNT_SATURATE) begin
                           pulse_count = '0;
                           digit_taken = 1'b0;
                        end
                        pulse_count = pulse_count + 1'b1;
                     end
                  end
               end
               awaiting_closure = 1'b0;
            end
         end
      end else if (w.now < last_poll) begin
         last_poll = w.now;
      end else if (w.now - last_poll >= dial_cfg.interdigit) begin
         last_poll = w.now;
         if (w.now >= last_pulse && pulse_count != '0 &&
             w.now - last_pulse >= dial_cfg.settle && !digit_taken) begin
            r.digit_valid = 1'b1;
            r.digit       = pulse_count % DIGIT_BASE;
            digit_taken   = 1'b1;
         end
      end
      return r;
   endfunction

   // mostly strictly inside the window, sometimes on its edges
   function automatic time_type pick_in(time_type lo, time_type hi);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return lo;
      if (roll == 1) return hi;
      if (hi > lo + 1) return lo + 1 + ($urandom % (hi - lo - 1));
      return lo + 1;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.min_closure = cfg_word_type'($urandom_range(0, 60));
      c.min_open    = cfg_word_type'($urandom_range(20, 80));
      c.max_open    = c.min_open + cfg_word_type'($urandom_range(2, 80));
      c.min_period  = cfg_word_type'($urandom_range(40, 120));
      c.max_period  = c.min_period + cfg_word_type'($urandom_range(0, 80));
      c.max_pulses  = count_type'($urandom_range(0, 15));
      c.interdigit  = cfg_word_type'($urandom_range(0, 600));
      c.settle      = cfg_word_type'($urandom_range(0, 700));
      return c;
   endfunction

   task automatic push_word(command_type cmd, logic closed);
      dial_words.push_back('{cmd, dial_now, closed});
   endtask

   task automatic add_pulse();
      time_type w, p, c;
      w = pick_in(time_type'(dial_cfg.min_open), time_type'(dial_cfg.max_open));
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 2 * dial_cfg.max_period + 2);
      else p = pick_in(time_type'(dial_cfg.min_period), time_type'(dial_cfg.max_period));
      if (p > w + dial_cfg.min_closure) c = p - w;
      else c = pick_in(time_type'(dial_cfg.min_closure), dial_cfg.min_closure + 4);
      if ($urandom_range(0, 19) == 0) c = $urandom_range(0, dial_cfg.min_closure);
      dial_now += c;
      push_word(CMD_LOOP_CHANGE, 1'b0);
      dial_now += w;
      push_word(CMD_LOOP_CHANGE, 1'b1);
   endtask

   task automatic add_poll(time_type gap);
      dial_now += gap;
      push_word(CMD_POLL, 1'($urandom_range(0, 1)));
   endtask

   task automatic add_digit();
      int unsigned n;
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(11, 17) : $urandom_range(1, 10);
      repeat (n) begin
         add_pulse();
         if ($urandom_range(0, 14) == 0) add_poll($urandom_range(0, dial_cfg.settle));
      end
      add_poll(($urandom_range(0, 4) == 0) ? $urandom_range(0, dial_cfg.settle) :
               dial_cfg.settle + $urandom_range(0, 40));
      repeat ($urandom_range(0, 2))
         add_poll($urandom_range(0, 1) ? dial_cfg.interdigit + $urandom_range(0, 3) :
                  $urandom_range(0, dial_cfg.interdigit));
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0:       dial_now = $urandom();
            1:       dial_now -= $urandom_range(1, 600);
            default: dial_now += $urandom_range(0, 300);
         endcase
         push_word(command_type'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic write_reg(reg_index_type idx, cfg_word_type value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         REG_MIN_CLOSURE: dial_cfg.min_closure = value;
         REG_MIN_OPEN:    dial_cfg.min_open    = value;
         REG_MAX_OPEN:    dial_cfg.max_open    = value;
         REG_MIN_PERIOD:  dial_cfg.min_period  = value;
         REG_MAX_PERIOD:  dial_cfg.max_period  = value;
         REG_MAX_PULSES:  dial_cfg.max_pulses  = value[CNT_WIDTH-1:0];
         REG_INTERDIGIT:  dial_cfg.interdigit  = value;
         REG_SETTLE:      dial_cfg.settle      = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_config(cfg_type c);
      write_reg(REG_MIN_CLOSURE, c.min_closure);
      write_reg(REG_MIN_OPEN, c.min_open);
      write_reg(REG_MAX_OPEN, c.max_open);
      write_reg(REG_MIN_PERIOD, c.min_period);
      write_reg(REG_MAX_PERIOD, c.max_period);
      write_reg(REG_MAX_PULSES, cfg_word_type'(c.max_pulses));
      write_reg(REG_INTERDIGIT, c.interdigit);
      write_reg(REG_SETTLE, c.settle);
      csr_we <= 1'b0;
   endtask

   task automatic send_word(item_type w, logic typed, result_type want);
      int unsigned gap;
      result_type  got;
      gap = ((sent_count / 64) % 4 == 0) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.command;
      req_tdata  <= {{(REQ_DATA_WIDTH-NOW_WIDTH-1){1'b0}}, w.loop_closed, w.now};
      do @(posedge clock); while (req_tready !== 1'b1);
      got = decode_word(w);
      pending_digits.push_back(typed ? want : got);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_digits.size() != 0);
      @(negedge clock);
   endtask

   initial begin
      cfg_type phase_cfg;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_word('{directed_rows[i].command, directed_rows[i].now, directed_rows[i].loop_closed},
                   directed_rows[i].typed, directed_rows[i].want);
      drain_results();
      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_cfg = '{RST_MIN_CLOSURE, RST_MIN_OPEN, RST_MAX_OPEN, RST_MIN_PERIOD,
                             RST_MAX_PERIOD, RST_MAX_PULSES, RST_INTERDIGIT, RST_SETTLE};
            1: phase_cfg = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, COUNT_SATURATE,
                             16'd0, 16'd0};
            2: phase_cfg = '0;
            3: phase_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd14,
                             16'hFFFF, 16'hFFFF};
            6: phase_cfg = '{RST_MIN_CLOSURE, RST_MIN_OPEN, RST_MAX_OPEN, RST_MIN_PERIOD,
                             RST_MAX_PERIOD, COUNT_SATURATE, RST_INTERDIGIT, RST_SETTLE};
            default: phase_cfg = random_cfg();
         endcase
         write_config(phase_cfg);
         // run through the timestamp wrap
         if (phase == 5) dial_now = 32'hFFFF_F000;
         while (dial_words.size() < PHASE_WORDS) begin
            if ($urandom_range(0, 3) == 0) add_noise();
            else add_digit();
         end
         while (dial_words.size() > 0) begin
            if (dial_words.size() == PHASE_WORDS / 2) drain_results();
            send_word(dial_words.pop_front(), 1'b0, NO_DIGIT);
         end
         drain_results();
      end
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      int unsigned stall;
      result_type  want;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         // long hold-off so the block backs up into its input
         if (results_seen % 500 == 250) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = ((results_seen / 80) % 4 == 1) ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         results_seen++;
         if (pending_digits.size() == 0) begin
            $error("result word with nothing pending: digit_valid %0b, digit %0d",
                   rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_tuser !== want.digit_valid) begin
               $error("digit_valid: expected %0b, actual %0b", want.digit_valid, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== {{(RSP_DATA_WIDTH-CNT_WIDTH){1'b0}}, want.digit}) begin
               $error("digit: expected %0d, actual %0d", want.digit, rsp_tdata);
               errors++;
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
